// ===== rtl/core/tdpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants of the trial division prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int DEFAULT_VALUE_BITS = 31;
  localparam int FIRST_DIVISOR      = 3;
  localparam int OUT_DATA_BITS      = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TEST,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new candidate, reset divisor to three
    logic div_start;  // begin a remainder computation
    logic div_step;   // one restoring-division bit
    logic advance;    // move to the next odd divisor
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below_two;
    logic is_two;
    logic is_even;
    logic square_above;  // divisor squared exceeds the candidate
    logic div_last;      // the current step is the final division bit
    logic rem_zero;
  } sts_t;

endpackage

// ===== rtl/core/tdpt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_datapath
// Candidate, odd divisor, running square of the divisor and a bit-serial
// restoring divider that produces the remainder of candidate by divisor.
// ----------------------------------------------------------------------------
module tdpt_datapath
  import tdpt_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [VALUE_BITS-1:0] candidate,
  output sts_t                  sts
);

  localparam int CW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] divisor;
  logic [VALUE_BITS:0]   square;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] dividend;
  logic [CW-1:0]         bit_cnt;

  logic [VALUE_BITS:0]   rem_shift;
  logic [VALUE_BITS:0]   rem_diff;
  logic [VALUE_BITS-1:0] rem_next;
  logic [VALUE_BITS:0]   divisor_x4;

  assign rem_shift  = {rem, dividend[VALUE_BITS-1]};
  assign rem_diff   = rem_shift - {1'b0, divisor};
  assign rem_next   = rem_diff[VALUE_BITS] ? rem_shift[VALUE_BITS-1:0]
                                           : rem_diff[VALUE_BITS-1:0];
  assign divisor_x4 = {divisor[VALUE_BITS-2:0], 2'b00};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value   <= candidate;
      divisor <= VALUE_BITS'(FIRST_DIVISOR);
      square  <= (VALUE_BITS+1)'(FIRST_DIVISOR * FIRST_DIVISOR);
    end else if (cmd.advance) begin
      // (d + 2)^2 = d^2 + 4d + 4
      divisor <= divisor + VALUE_BITS'(2);
      square  <= square + divisor_x4 + (VALUE_BITS+1)'(4);
    end
    if (cmd.div_start) begin
      rem      <= '0;
      dividend <= value;
    end else if (cmd.div_step) begin
      rem      <= rem_next;
      dividend <= {dividend[VALUE_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
    end else if (cmd.div_start) begin
      bit_cnt <= CW'(VALUE_BITS - 1);
    end else if (cmd.div_step && bit_cnt != '0) begin
      bit_cnt <= bit_cnt - CW'(1);
    end
  end

  always_comb begin
    sts.below_two    = (value < VALUE_BITS'(2));
    sts.is_two       = (value == VALUE_BITS'(2));
    sts.is_even      = ~value[0];
    sts.square_above = (square > {1'b0, value});
    sts.div_last     = (bit_cnt == '0);
    sts.rem_zero     = (rem == '0);
  end

endmodule

// ===== rtl/core/tdpt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequencer of the prime test and the result register of the output side.
// ----------------------------------------------------------------------------
module tdpt_ctrl
  import tdpt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic prime_flag,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state, state_next;
  logic   verdict, verdict_next;
  logic   out_valid_next;
  logic   prime_flag_next;
  logic   out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    verdict    <= verdict_next;
    prime_flag <= prime_flag_next;
  end

  always_comb begin
    state_next   = state;
    verdict_next = verdict;
    cmd          = '0;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.below_two) begin
          verdict_next = 1'b0;
          state_next   = ST_DONE;
        end else if (sts.is_two) begin
          verdict_next = 1'b1;
          state_next   = ST_DONE;
        end else if (sts.is_even) begin
          verdict_next = 1'b0;
          state_next   = ST_DONE;
        end else if (sts.square_above) begin
          verdict_next = 1'b1;
          state_next   = ST_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts.rem_zero) begin
          verdict_next = 1'b0;
          state_next   = ST_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_DONE: begin
        // Wait only until the output register has room.
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next  = (out_valid && !out_ready) || out_load;
    prime_flag_next = out_load ? verdict : prime_flag;
  end

endmodule

// ===== rtl/core/trial_division_prime_test_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Trial division primality test with stream input and output.
// ----------------------------------------------------------------------------
// Each input beat carries one unsigned candidate; one output beat answers
// with a flag that is 1 when the candidate is prime. Zero and one are not
// prime, two is prime and other even values are rejected at once. Odd
// candidates are divided by 3, 5, 7, ... while the divisor squared does not
// exceed the candidate. Each divisor passes through the check state, the
// bit-serial remainder unit and the remainder test, and a prime v tries up to
// roughly sqrt(v) / 2 divisors; even values and small values are answered
// from the check state alone. One candidate is processed at a time; the next
// one is accepted as soon as the previous result has moved into the output
// register.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top
  import tdpt_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // Bits from 0: candidate (VALUE_BITS), zero fill.
  input  logic [((VALUE_BITS+7)/8)*8-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // Bits from 0: prime_flag (1), zero fill.
  output logic [OUT_DATA_BITS-1:0]           m_tdata
);

  cmd_t cmd;
  sts_t sts;
  logic prime_flag;

  tdpt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .prime_flag (prime_flag),
    .cmd        (cmd),
    .sts        (sts)
  );

  tdpt_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .candidate (s_tdata[VALUE_BITS-1:0]),
    .sts       (sts)
  );

  assign m_tdata = {{(OUT_DATA_BITS-1){1'b0}}, prime_flag};

endmodule
